### src/pzr_pkg.sv
// ----------------------------------------------------------------------------
// pzr_pkg : shared types and constants for the pan/zoom velocity ramp
// Field widths, register indexes, reset values and the velocity ramp step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pzr_pkg;

  // Field widths
  localparam int ACC_W  = 16;   // accel_step, velocity_limit
  localparam int VEL_W  = 17;   // signed velocity
  localparam int POS_W  = 32;   // signed Q16.16 centre
  localparam int EXT_W  = 31;   // unsigned Q15.16 half extent
  localparam int DATA_W = 32;   // configuration data
  localparam int ADDR_W = 5;    // six registers at 4-byte spacing
  localparam int IDX_W  = 3;

  localparam int VEL_FRAC_BITS_DEF = 16;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_ACCEL   = 3'd0;
  localparam logic [IDX_W-1:0] REG_LIMIT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_START_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_START_W = 3'd4;
  localparam logic [IDX_W-1:0] REG_START_H = 3'd5;

  // Reset values
  localparam logic [ACC_W-1:0] ACCEL_RST = 16'd655;
  localparam logic [ACC_W-1:0] LIMIT_RST = 16'd6553;
  localparam logic [EXT_W-1:0] EXT_ONE   = 31'd65536;

  typedef struct packed {
    logic        [ACC_W-1:0] accel;
    logic        [ACC_W-1:0] limit;
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic        [EXT_W-1:0] start_w;
    logic        [EXT_W-1:0] start_h;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic move_up;
    logic move_down;
    logic move_left;
    logic move_right;
    logic zoom_in;
    logic zoom_out;
  } cmd_t;

  // Velocities handed from the ramp stage to the integration stage
  typedef struct packed {
    logic                    load;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] vz;
  } vel_stage_t;

  // One axis of the ramp: step toward the command and clamp, or decay to zero
  function automatic logic signed [VEL_W-1:0] ramp_vel(
    input logic signed [VEL_W-1:0] v,
    input logic                    pos,
    input logic                    neg,
    input logic        [ACC_W-1:0] a,
    input logic        [ACC_W-1:0] lim
  );
    logic signed [VEL_W:0] n;
    logic signed [VEL_W:0] v_s;
    logic signed [VEL_W:0] a_s;
    logic signed [VEL_W:0] l_s;
    v_s = {v[VEL_W-1], v};
    a_s = $signed({{(VEL_W+1-ACC_W){1'b0}}, a});
    l_s = $signed({{(VEL_W+1-ACC_W){1'b0}}, lim});
    if (pos != neg) begin
      n = pos ? v_s + a_s : v_s - a_s;
      if (n > l_s) n = l_s;
      else if (n < -l_s) n = -l_s;
    end else if (v_s > 0) begin
      n = v_s - a_s;
      if (n < 0) n = '0;
    end else if (v_s < 0) begin
      n = v_s + a_s;
      if (n > 0) n = '0;
    end else begin
      n = '0;
    end
    return n[VEL_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/pzr_if.sv
// ----------------------------------------------------------------------------
// pzr_if : command and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pzr_in_if;
  import pzr_pkg::*;
  logic valid;
  logic ready;
  logic load;
  logic move_up;
  logic move_down;
  logic move_left;
  logic move_right;
  logic zoom_in;
  logic zoom_out;

  modport source (output valid, load, move_up, move_down, move_left, move_right,
                  zoom_in, zoom_out, input ready);
  modport sink   (input valid, load, move_up, move_down, move_left, move_right,
                  zoom_in, zoom_out, output ready);
endinterface

interface pzr_out_if;
  import pzr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic        [EXT_W-1:0] width;
  logic        [EXT_W-1:0] height;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;

  modport source (output valid, pos_x, pos_y, width, height, vel_x, vel_y, vel_z,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, width, height, vel_x, vel_y, vel_z,
                  output ready);
endinterface

`default_nettype wire

### src/pzr_cfg.sv
// ----------------------------------------------------------------------------
// pzr_cfg : configuration registers
// APB-style register file for ramp rate, limit and start view.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pzr_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [pzr_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [pzr_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [pzr_pkg::DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready,
  output pzr_pkg::cfg_t                   cfg
);
  import pzr_pkg::*;

  cfg_t             cfg_r;
  logic             wr_en;
  logic [IDX_W-1:0] idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = cfg_paddr[ADDR_W-1:2];
  assign cfg        = cfg_r;

  // Write on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel   <= ACCEL_RST;
      cfg_r.limit   <= LIMIT_RST;
      cfg_r.start_x <= '0;
      cfg_r.start_y <= '0;
      cfg_r.start_w <= EXT_ONE;
      cfg_r.start_h <= EXT_ONE;
    end else if (wr_en) begin
      case (idx)
        REG_ACCEL:   cfg_r.accel   <= cfg_pwdata[ACC_W-1:0];
        REG_LIMIT:   cfg_r.limit   <= cfg_pwdata[ACC_W-1:0];
        REG_START_X: cfg_r.start_x <= $signed(cfg_pwdata[POS_W-1:0]);
        REG_START_Y: cfg_r.start_y <= $signed(cfg_pwdata[POS_W-1:0]);
        REG_START_W: cfg_r.start_w <= cfg_pwdata[EXT_W-1:0];
        REG_START_H: cfg_r.start_h <= cfg_pwdata[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_ACCEL:   cfg_prdata = {{(DATA_W-ACC_W){1'b0}}, cfg_r.accel};
      REG_LIMIT:   cfg_prdata = {{(DATA_W-ACC_W){1'b0}}, cfg_r.limit};
      REG_START_X: cfg_prdata = cfg_r.start_x;
      REG_START_Y: cfg_prdata = cfg_r.start_y;
      REG_START_W: cfg_prdata = {{(DATA_W-EXT_W){1'b0}}, cfg_r.start_w};
      REG_START_H: cfg_prdata = {{(DATA_W-EXT_W){1'b0}}, cfg_r.start_h};
      default:     cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### src/pzr_ramp.sv
// ----------------------------------------------------------------------------
// pzr_ramp : velocity ramp stage
// Holds the three axis velocities and steps them once per accepted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pzr_ramp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 accept,
  input  wire logic                 advance,
  input  wire pzr_pkg::cmd_t        cmd,
  input  wire pzr_pkg::cfg_t        cfg,
  output logic                      stage_valid,
  output pzr_pkg::vel_stage_t       stage
);
  import pzr_pkg::*;

  logic                    valid_r;
  logic                    load_r;
  logic signed [VEL_W-1:0] vx_r, vy_r, vz_r;
  logic signed [VEL_W-1:0] vx_nxt, vy_nxt, vz_nxt;

  // Next velocities; load zeroes them
  always_comb begin
    if (cmd.load) begin
      vx_nxt = '0;
      vy_nxt = '0;
      vz_nxt = '0;
    end else begin
      vx_nxt = ramp_vel(vx_r, cmd.move_right, cmd.move_left, cfg.accel, cfg.limit);
      vy_nxt = ramp_vel(vy_r, cmd.move_up, cmd.move_down, cfg.accel, cfg.limit);
      vz_nxt = ramp_vel(vz_r, cmd.zoom_out, cmd.zoom_in, cfg.accel, cfg.limit);
    end
  end

  // Update velocity state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      load_r  <= 1'b0;
      vx_r    <= '0;
      vy_r    <= '0;
      vz_r    <= '0;
    end else begin
      if (accept) begin
        valid_r <= 1'b1;
        load_r  <= cmd.load;
        vx_r    <= vx_nxt;
        vy_r    <= vy_nxt;
        vz_r    <= vz_nxt;
      end else if (advance) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign stage_valid = valid_r;
  assign stage.load  = load_r;
  assign stage.vx    = vx_r;
  assign stage.vy    = vy_r;
  assign stage.vz    = vz_r;

endmodule

`default_nettype wire

### src/pzr_integ.sv
// ----------------------------------------------------------------------------
// pzr_integ : position and extent integration
// Moves the centre by velocity times extent and scales the extents by
// one plus the zoom velocity; its state registers are the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pzr_integ #(
  parameter int VEL_FRAC_BITS = pzr_pkg::VEL_FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               advance,
  input  wire logic                               out_ready,
  input  wire pzr_pkg::vel_stage_t                stage,
  input  wire pzr_pkg::cfg_t                      cfg,
  output logic                                    out_valid,
  output logic signed [pzr_pkg::POS_W-1:0]        pos_x,
  output logic signed [pzr_pkg::POS_W-1:0]        pos_y,
  output logic        [pzr_pkg::EXT_W-1:0]        width,
  output logic        [pzr_pkg::EXT_W-1:0]        height,
  output logic signed [pzr_pkg::VEL_W-1:0]        vel_x,
  output logic signed [pzr_pkg::VEL_W-1:0]        vel_y,
  output logic signed [pzr_pkg::VEL_W-1:0]        vel_z
);
  import pzr_pkg::*;

  localparam int F  = VEL_FRAC_BITS;
  // Centre product: signed velocity by positive extent
  localparam int PW = VEL_W + EXT_W + 1;
  // Scale factor 2^F + v_z
  localparam int SW = ((F > VEL_W - 1) ? F : VEL_W - 1) + 2;
  // Extent product
  localparam int EW = EXT_W + 1 + SW;

  localparam logic signed [PW:0] P_HALF = {{PW{1'b0}}, 1'b1} << (F - 1);
  localparam logic signed [PW:0] P_MAX  = {{(PW+2-POS_W){1'b0}}, {(POS_W-1){1'b1}}};
  localparam logic signed [PW:0] P_MIN  = {{(PW+2-POS_W){1'b1}}, {(POS_W-1){1'b0}}};
  localparam logic signed [EW:0] E_HALF = {{EW{1'b0}}, 1'b1} << (F - 1);
  localparam logic signed [EW:0] E_MAX  = {{(EW+1-EXT_W){1'b0}}, {EXT_W{1'b1}}};
  localparam logic signed [EW:0] E_ONE  = {{EW{1'b0}}, 1'b1};
  localparam logic signed [SW-1:0] S_ONE = {{(SW-1){1'b0}}, 1'b1} << F;

  // Centre step, rounded to nearest with ties upward, saturated
  function automatic logic signed [POS_W-1:0] pos_step(
    input logic signed [POS_W-1:0] c,
    input logic signed [VEL_W-1:0] v,
    input logic        [EXT_W-1:0] e
  );
    logic signed [PW-1:0] prod;
    logic signed [PW:0]   rnd;
    logic signed [PW:0]   sum;
    prod = v * $signed({1'b0, e});
    rnd  = ($signed({prod[PW-1], prod}) + P_HALF) >>> F;
    sum  = rnd + $signed({{(PW+1-POS_W){c[POS_W-1]}}, c});
    if (sum > P_MAX) sum = P_MAX;
    else if (sum < P_MIN) sum = P_MIN;
    return sum[POS_W-1:0];
  endfunction

  // Extent scale, rounded, saturated to one LSB .. full scale
  function automatic logic [EXT_W-1:0] ext_step(
    input logic        [EXT_W-1:0] e,
    input logic signed [SW-1:0]    s
  );
    logic signed [EW-1:0] prod;
    logic signed [EW:0]   rnd;
    prod = $signed({1'b0, e}) * s;
    rnd  = ($signed({prod[EW-1], prod}) + E_HALF) >>> F;
    if (rnd < E_ONE) rnd = E_ONE;
    else if (rnd > E_MAX) rnd = E_MAX;
    return rnd[EXT_W-1:0];
  endfunction

  logic                    valid_r;
  logic signed [POS_W-1:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic        [EXT_W-1:0] ex_r, ey_r, ex_nxt, ey_nxt;
  logic signed [VEL_W-1:0] vx_r, vy_r, vz_r;
  logic signed [SW-1:0]    scale;

  assign scale = S_ONE + $signed({{(SW-VEL_W){stage.vz[VEL_W-1]}}, stage.vz});

  // Load the start view, or integrate one tick
  always_comb begin
    if (stage.load) begin
      cx_nxt = cfg.start_x;
      cy_nxt = cfg.start_y;
      ex_nxt = (cfg.start_w == '0) ? {{(EXT_W-1){1'b0}}, 1'b1} : cfg.start_w;
      ey_nxt = (cfg.start_h == '0) ? {{(EXT_W-1){1'b0}}, 1'b1} : cfg.start_h;
    end else begin
      cx_nxt = pos_step(cx_r, stage.vx, ex_r);
      cy_nxt = pos_step(cy_r, stage.vy, ey_r);
      ex_nxt = ext_step(ex_r, scale);
      ey_nxt = ext_step(ey_r, scale);
    end
  end

  // Advance state and the result beat together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cx_r    <= '0;
      cy_r    <= '0;
      ex_r    <= EXT_ONE;
      ey_r    <= EXT_ONE;
    end else begin
      if (advance) begin
        valid_r <= 1'b1;
        cx_r    <= cx_nxt;
        cy_r    <= cy_nxt;
        ex_r    <= ex_nxt;
        ey_r    <= ey_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // Velocity copy for the result beat
  always_ff @(posedge clk) begin
    if (advance) begin
      vx_r <= stage.vx;
      vy_r <= stage.vy;
      vz_r <= stage.vz;
    end
  end

  assign out_valid = valid_r;
  assign pos_x     = cx_r;
  assign pos_y     = cy_r;
  assign width     = ex_r;
  assign height    = ey_r;
  assign vel_x     = vx_r;
  assign vel_y     = vy_r;
  assign vel_z     = vz_r;

endmodule

`default_nettype wire

### src/pan_zoom_velocity_ramp.sv
// ----------------------------------------------------------------------------
// pan_zoom_velocity_ramp : pan and zoom motion with velocity ramps
// Ramps three axis velocities per tick, then integrates centre and extents.
//
//   channel   direction  beat contents
//   in_chan   sink       load, move_up/down/left/right, zoom_in/out
//   out_chan  source     pos_x, pos_y, width, height, vel_x, vel_y, vel_z
//   cfg_*     slave      APB writes and reads of the six registers
//
// One beat per cycle unless the result stalls; a command passes ramp, then integration.
// The velocity loop sits in the ramp stage, the multiply and saturate loop of
// centre and extents in the integration stage, whose state is the result beat.
// Synchronous active-low reset restores the default registers and view.
// A stalled result holds; one further command is still taken into the ramp stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pan_zoom_velocity_ramp #(
  parameter int VEL_FRAC_BITS = pzr_pkg::VEL_FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  pzr_in_if.sink                          in_chan,
  pzr_out_if.source                       out_chan,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [pzr_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [pzr_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [pzr_pkg::DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import pzr_pkg::*;

  cfg_t       cfg;
  cmd_t       cmd;
  vel_stage_t stage;
  logic       stage_valid;
  logic       advance;
  logic       accept;
  logic       out_valid;

  // Move the ramp stage on when the result slot is free or being taken
  assign advance       = stage_valid && (!out_valid || out_chan.ready);
  assign in_chan.ready = !stage_valid || advance;
  assign accept        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid;

  assign cmd.load       = in_chan.load;
  assign cmd.move_up    = in_chan.move_up;
  assign cmd.move_down  = in_chan.move_down;
  assign cmd.move_left  = in_chan.move_left;
  assign cmd.move_right = in_chan.move_right;
  assign cmd.zoom_in    = in_chan.zoom_in;
  assign cmd.zoom_out   = in_chan.zoom_out;

  pzr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  pzr_ramp u_ramp (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .advance     (advance),
    .cmd         (cmd),
    .cfg         (cfg),
    .stage_valid (stage_valid),
    .stage       (stage)
  );

  pzr_integ #(
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_integ (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .out_ready (out_chan.ready),
    .stage     (stage),
    .cfg       (cfg),
    .out_valid (out_valid),
    .pos_x     (out_chan.pos_x),
    .pos_y     (out_chan.pos_y),
    .width     (out_chan.width),
    .height    (out_chan.height),
    .vel_x     (out_chan.vel_x),
    .vel_y     (out_chan.vel_y),
    .vel_z     (out_chan.vel_z)
  );

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench : pan/zoom velocity ramp
// Drives frame ticks through the command channel and APB register writes,
// predicts each result beat from a local model of the ramp and integration
// and compares every field of every result beat, under random idling on
// both channels and one long result hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pzr_pkg::*;

  localparam int     FRAC   = VEL_FRAC_BITS_DEF;
  localparam longint POS_HI = 64'sd2147483647;
  localparam longint POS_LO = -64'sd2147483648;
  localparam longint EXT_HI = 64'sd2147483647;

  // One result beat as the block presents it
  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic        [EXT_W-1:0] width;
    logic        [EXT_W-1:0] height;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] vel_z;
  } view_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  pzr_in_if  in_chan ();
  pzr_out_if out_chan ();

  pan_zoom_velocity_ramp #(.VEL_FRAC_BITS(FRAC)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Shadow registers and view state of the motion model
  cfg_t                    shadow_cfg;
  logic signed [VEL_W-1:0] vel_x_m;
  logic signed [VEL_W-1:0] vel_y_m;
  logic signed [VEL_W-1:0] vel_z_m;
  longint                  cen_x;
  longint                  cen_y;
  longint                  ext_x;
  longint                  ext_y;
  view_t                   pending_views[$];

  int fail_count    = 0;
  int shown_count   = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left    = 0;

  initial begin : clock_gen
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    #(2_000_000);
    $display("testbench: done, errors");
    $finish;
  end

  // Log the first few failures, count them all
  task automatic note_failure(string msg);
    fail_count++;
    if (shown_count < 10) $display("%s", msg);
    shown_count++;
  endtask

  // Bring a Q15.16 x Q1.16 product back to Q16.16, ties toward +infinity
  function automatic longint round_q16(longint p);
    return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Step one axis toward its command, or decay to zero without crossing
  function automatic logic signed [VEL_W-1:0] ramp_axis(logic signed [VEL_W-1:0] v,
                                                        logic pos, logic neg);
    longint n;
    longint a;
    longint lim;
    n   = longint'(v);
    a   = longint'(shadow_cfg.accel);
    lim = longint'(shadow_cfg.limit);
    if (pos != neg) begin
      n = pos ? n + a : n - a;
      if (n > lim) n = lim;
      else if (n < -lim) n = -lim;
    end else if (n > 0) begin
      n = n - a;
      if (n < 0) n = 0;
    end else if (n < 0) begin
      n = n + a;
      if (n > 0) n = 0;
    end
    return n[VEL_W-1:0];
  endfunction

  function automatic cmd_t cmd(bit ld, bit up, bit dn, bit lf, bit rt, bit zi, bit zo);
    cmd_t c;
    c.load       = ld;
    c.move_up    = up;
    c.move_down  = dn;
    c.move_left  = lf;
    c.move_right = rt;
    c.zoom_in    = zi;
    c.zoom_out   = zo;
    return c;
  endfunction

  // Advance the view by one tick and queue the beat it produces
  task automatic advance_view(cmd_t c);
    view_t  e;
    longint scale;
    if (c.load) begin
      cen_x   = longint'(shadow_cfg.start_x);
      cen_y   = longint'(shadow_cfg.start_y);
      ext_x   = (shadow_cfg.start_w == '0) ? 1 : longint'(shadow_cfg.start_w);
      ext_y   = (shadow_cfg.start_h == '0) ? 1 : longint'(shadow_cfg.start_h);
      vel_x_m = '0;
      vel_y_m = '0;
      vel_z_m = '0;
    end else begin
      vel_x_m = ramp_axis(vel_x_m, c.move_right, c.move_left);
      vel_y_m = ramp_axis(vel_y_m, c.move_up, c.move_down);
      vel_z_m = ramp_axis(vel_z_m, c.zoom_out, c.zoom_in);
      // centre moves by the new velocity times the old extent
      cen_x = clip(cen_x + round_q16(longint'(vel_x_m) * ext_x), POS_LO, POS_HI);
      cen_y = clip(cen_y + round_q16(longint'(vel_y_m) * ext_y), POS_LO, POS_HI);
      scale = (longint'(1) <<< FRAC) + longint'(vel_z_m);
      ext_x = clip(round_q16(ext_x * scale), 1, EXT_HI);
      ext_y = clip(round_q16(ext_y * scale), 1, EXT_HI);
    end
    e.pos_x  = cen_x[POS_W-1:0];
    e.pos_y  = cen_y[POS_W-1:0];
    e.width  = ext_x[EXT_W-1:0];
    e.height = ext_y[EXT_W-1:0];
    e.vel_x  = vel_x_m;
    e.vel_y  = vel_y_m;
    e.vel_z  = vel_z_m;
    pending_views.push_back(e);
  endtask

  // Offer one tick, with random gaps first; valid stays high for the next call
  task automatic send_tick(cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.load       <= c.load;
    in_chan.move_up    <= c.move_up;
    in_chan.move_down  <= c.move_down;
    in_chan.move_left  <= c.move_left;
    in_chan.move_right <= c.move_right;
    in_chan.zoom_in    <= c.zoom_in;
    in_chan.zoom_out   <= c.zoom_out;
    do @(posedge clk); while (!in_chan.ready);
    advance_view(c);
  endtask

  // Stop offering and wait for every queued beat to drain
  task automatic settle_idle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write, then read back and compare with the masked value
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] want;
    case (idx)
      REG_ACCEL: begin
        shadow_cfg.accel = data[ACC_W-1:0];
        want = DATA_W'(data[ACC_W-1:0]);
      end
      REG_LIMIT: begin
        shadow_cfg.limit = data[ACC_W-1:0];
        want = DATA_W'(data[ACC_W-1:0]);
      end
      REG_START_X: begin
        shadow_cfg.start_x = data;
        want = data;
      end
      REG_START_Y: begin
        shadow_cfg.start_y = data;
        want = data;
      end
      REG_START_W: begin
        shadow_cfg.start_w = data[EXT_W-1:0];
        want = DATA_W'(data[EXT_W-1:0]);
      end
      REG_START_H: begin
        shadow_cfg.start_h = data[EXT_W-1:0];
        want = DATA_W'(data[EXT_W-1:0]);
      end
      default: want = '0;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want)
      note_failure($sformatf("register %0d reads %h, expected %h", idx, cfg_prdata, want));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  function automatic logic [ACC_W-1:0] pick_rate();
    case ($urandom_range(6))
      0:       return '0;
      1:       return '1;
      2:       return ACC_W'(1);
      3:       return ACC_W'($urandom);
      default: return ACC_W'($urandom_range(3000, 1));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_start_pos();
    case ($urandom_range(5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return DATA_W'($urandom);
      default: return DATA_W'($urandom_range(2000000)) - 32'd1000000;
    endcase
  endfunction

  // Extent with a random top bit so the 31-bit mask is exercised
  function automatic logic [DATA_W-1:0] pick_start_ext();
    logic [DATA_W-1:0] v;
    case ($urandom_range(5))
      0:       v = '0;
      1:       v = 32'h7FFF_FFFF;
      2:       v = 32'd1;
      default: v = DATA_W'($urandom_range(400000, 2000));
    endcase
    v[DATA_W-1] = 1'($urandom);
    return v;
  endfunction

  // Defaults after reset: idle tick, load priority, ramp and mixed decay
  task automatic test_reset_defaults();
    send_tick(cmd(0, 0, 0, 0, 0, 0, 0));
    send_tick(cmd(1, 1, 1, 1, 1, 1, 1));
    send_tick(cmd(0, 0, 0, 0, 1, 0, 0));
    send_tick(cmd(0, 1, 0, 0, 1, 0, 1));
    send_tick(cmd(0, 1, 1, 1, 1, 1, 1));
  endtask

  // Full-scale rates: centre saturation, zero start extent, extent collapse
  task automatic test_extreme_view();
    settle_idle();
    write_reg(REG_ACCEL, 32'hFFFF_FFFF);
    write_reg(REG_LIMIT, 32'h0000_FFFF);
    write_reg(REG_START_X, 32'h7FFF_FFFF);
    write_reg(REG_START_Y, 32'h8000_0000);
    write_reg(REG_START_W, 32'hFFFF_FFFF);
    write_reg(REG_START_H, 32'h0000_0000);
    send_tick(cmd(1, 0, 0, 0, 0, 0, 0));
    send_tick(cmd(0, 0, 1, 0, 1, 0, 1));
    send_tick(cmd(0, 0, 1, 0, 1, 0, 1));
    send_tick(cmd(0, 0, 0, 0, 0, 1, 0));
    send_tick(cmd(0, 0, 0, 0, 0, 1, 0));
    send_tick(cmd(0, 0, 0, 0, 0, 1, 0));
    send_tick(cmd(0, 0, 0, 0, 0, 1, 0));
    send_tick(cmd(0, 1, 0, 1, 0, 0, 0));
    send_tick(cmd(0, 0, 0, 0, 0, 0, 0));
    send_tick(cmd(0, 1, 1, 1, 1, 0, 0));
  endtask

  // Lower the limit under a running velocity: decay ignores it, a command clamps
  task automatic test_limit_lowered();
    settle_idle();
    write_reg(REG_ACCEL, 32'd4000);
    write_reg(REG_LIMIT, 32'd65535);
    write_reg(REG_START_X, 32'd0);
    write_reg(REG_START_Y, 32'd0);
    write_reg(REG_START_W, 32'd196608);
    write_reg(REG_START_H, 32'd65536);
    send_tick(cmd(1, 0, 0, 0, 0, 0, 0));
    repeat (3) send_tick(cmd(0, 0, 0, 0, 1, 0, 0));
    settle_idle();
    write_reg(REG_LIMIT, 32'd100);
    write_reg(REG_ACCEL, 32'd1000);
    repeat (3) send_tick(cmd(0, 0, 0, 0, 0, 0, 0));
    send_tick(cmd(0, 0, 0, 0, 1, 0, 0));
  endtask

  // Random registers, then runs of held commands with some noise mixed in
  task automatic test_random_motion(int n_items);
    cmd_t pattern;
    cmd_t c;
    int   run;
    int   sent;
    settle_idle();
    write_reg(REG_ACCEL, {16'($urandom), pick_rate()});
    write_reg(REG_LIMIT, {16'($urandom), pick_rate()});
    write_reg(REG_START_X, pick_start_pos());
    write_reg(REG_START_Y, pick_start_pos());
    write_reg(REG_START_W, pick_start_ext());
    write_reg(REG_START_H, pick_start_ext());
    send_tick(cmd(1, 0, 0, 0, 0, 0, 0));
    sent = 0;
    while (sent < n_items) begin
      pattern      = cmd_t'(7'($urandom));
      pattern.load = ($urandom_range(24) == 0);
      run          = $urandom_range(24, 1);
      for (int k = 0; k < run && sent < n_items; k++) begin
        c = ($urandom_range(9) == 0) ? cmd_t'(7'($urandom)) : pattern;
        send_tick(c);
        sent++;
      end
    end
  endtask

  // Hold the result side off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    int   saved_pct;
    cmd_t c;
    settle_idle();
    saved_pct     = send_idle_pct;
    send_idle_pct = 0;
    stall_left    = 300;
    repeat (40) begin
      c      = cmd_t'(7'($urandom));
      c.load = 1'b0;
      send_tick(c);
    end
    send_idle_pct = saved_pct;
  endtask

  // Result side: random ready, or a counted hold-off when one is asked
  initial begin : result_sink
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted result beat with the oldest predicted view
  initial begin : result_check
    view_t e;
    logic  bad;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (pending_views.size() == 0) begin
          note_failure("result beat with no tick pending");
        end else begin
          e   = pending_views.pop_front();
          bad = (e.pos_x !== out_chan.pos_x) || (e.pos_y !== out_chan.pos_y) ||
                (e.width !== out_chan.width) || (e.height !== out_chan.height) ||
                (e.vel_x !== out_chan.vel_x) || (e.vel_y !== out_chan.vel_y) ||
                (e.vel_z !== out_chan.vel_z);
          if (bad)
            note_failure($sformatf({"mismatch: exp pos %0d,%0d ext %0d,%0d vel %0d,%0d,%0d",
                                    " got pos %0d,%0d ext %0d,%0d vel %0d,%0d,%0d"},
                                   e.pos_x, e.pos_y, e.width, e.height,
                                   e.vel_x, e.vel_y, e.vel_z,
                                   out_chan.pos_x, out_chan.pos_y, out_chan.width,
                                   out_chan.height, out_chan.vel_x, out_chan.vel_y,
                                   out_chan.vel_z));
        end
      end
    end
  end

  initial begin : run_tests
    // Initialise every input and hold reset
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.load       = 1'b0;
    in_chan.move_up    = 1'b0;
    in_chan.move_down  = 1'b0;
    in_chan.move_left  = 1'b0;
    in_chan.move_right = 1'b0;
    in_chan.zoom_in    = 1'b0;
    in_chan.zoom_out   = 1'b0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    shadow_cfg.accel   = ACCEL_RST;
    shadow_cfg.limit   = LIMIT_RST;
    shadow_cfg.start_x = '0;
    shadow_cfg.start_y = '0;
    shadow_cfg.start_w = EXT_ONE;
    shadow_cfg.start_h = EXT_ONE;
    vel_x_m            = '0;
    vel_y_m            = '0;
    vel_z_m            = '0;
    cen_x              = 0;
    cen_y              = 0;
    ext_x              = 65536;
    ext_y              = 65536;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 32;
    recv_idle_pct = 48;
    test_reset_defaults();
    test_extreme_view();
    test_limit_lowered();
    test_random_motion(122);
    test_random_motion(122);

    send_idle_pct = 48;
    recv_idle_pct = 32;
    test_random_motion(122);
    test_random_motion(122);
    test_backpressure();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_motion(122);
    test_random_motion(122);
    test_random_motion(122);
    test_random_motion(122);

    // Drain, allow the pipeline to empty, then report
    settle_idle();
    repeat (8) @(posedge clk);
    if (pending_views.size() != 0)
      note_failure($sformatf("%0d result beats never arrived", pending_views.size()));
    if (fail_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### pan_zoom_velocity_ramp.f
src/pzr_pkg.sv
src/pzr_if.sv
src/pzr_cfg.sv
src/pzr_ramp.sv
src/pzr_integ.sv
src/pan_zoom_velocity_ramp.sv
tb/sv/testbench.sv
